// ===== src/lppp_pkg.sv =====
// Shared types and constants for the lidar point to pixel projection block.
`timescale 1ns / 1ps
package lppp_pkg;
   localparam int IMAGE_WIDTH  = 1920;
   localparam int IMAGE_HEIGHT = 1080;
   localparam int QW    = 14;        // quotient bits, enough for limits up to 8192
   localparam int ACCW  = 67;        // sum of three 64-bit products and a 64-bit constant term
   localparam int PIXW  = 11;
   localparam int NREG  = 6;
   localparam int IDXW  = 3;
   localparam int DIVST = QW;        // one quotient bit per stage

   localparam logic [IDXW-1:0] REG_COL_A   = 3'd0;
   localparam logic [IDXW-1:0] REG_COL_B   = 3'd1;
   localparam logic [IDXW-1:0] REG_ROW_A   = 3'd2;
   localparam logic [IDXW-1:0] REG_ROW_B   = 3'd3;
   localparam logic [IDXW-1:0] REG_DEPTH_A = 3'd4;
   localparam logic [IDXW-1:0] REG_DEPTH_B = 3'd5;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic signed [31:0] ck;
   } row_coef_type;
endpackage

// ===== src/lppp_row_eval.sv =====
// Three-stage evaluation of one projection row: products, pair sums, total.
`timescale 1ns / 1ps
module lppp_row_eval (
   input  logic                          clock,
   input  lppp_pkg::row_coef_type        coef,
   input  lppp_pkg::point_type           pt,
   output logic signed [lppp_pkg::ACCW-1:0] sum
);
   import lppp_pkg::*;
   logic signed [63:0] px_ff, py_ff, pz_ff, pk_ff;
   logic signed [ACCW-1:0] s0_ff, s1_ff, sum_ff;

   always_ff @(posedge clock) begin
      px_ff  <= coef.cx * pt.x;
      py_ff  <= coef.cy * pt.y;
      pz_ff  <= coef.cz * pt.z;
      pk_ff  <= {{16{coef.ck[31]}}, coef.ck, 16'd0};
      s0_ff  <= ACCW'(px_ff) + ACCW'(py_ff);
      s1_ff  <= ACCW'(pz_ff) + ACCW'(pk_ff);
      sum_ff <= s0_ff + s1_ff;
   end
   assign sum = sum_ff;
endmodule

// ===== src/lppp_div_stage.sv =====
// One restoring division step for column and row, with the divisor carried along.
`timescale 1ns / 1ps
module lppp_div_stage (
   input  logic                          clock,
   input  logic [3:0]                    bit_sel,
   input  logic [lppp_pkg::ACCW-1:0]     d,
   input  logic [lppp_pkg::ACCW-1:0]     rem_c,
   input  logic [lppp_pkg::ACCW-1:0]     rem_r,
   input  logic [lppp_pkg::QW-1:0]       q_c,
   input  logic [lppp_pkg::QW-1:0]       q_r,
   output logic [lppp_pkg::ACCW-1:0]     d_o,
   output logic [lppp_pkg::ACCW-1:0]     rem_c_o,
   output logic [lppp_pkg::ACCW-1:0]     rem_r_o,
   output logic [lppp_pkg::QW-1:0]       q_c_o,
   output logic [lppp_pkg::QW-1:0]       q_r_o
);
   import lppp_pkg::*;
   logic [ACCW+QW-1:0] t;
   logic cge, rge;
   assign t   = {{QW{1'b0}}, d} << bit_sel;
   assign cge = {{QW{1'b0}}, rem_c} >= t;
   assign rge = {{QW{1'b0}}, rem_r} >= t;
   always_ff @(posedge clock) begin
      d_o     <= d;
      rem_c_o <= cge ? rem_c - t[ACCW-1:0] : rem_c;
      rem_r_o <= rge ? rem_r - t[ACCW-1:0] : rem_r;
      q_c_o   <= q_c | (QW'(cge) << bit_sel);
      q_r_o   <= q_r | (QW'(rge) << bit_sel);
   end
endmodule

// ===== src/lidar_point_to_pixel_projection_top.sv =====
// Top level: coefficient registers, row evaluation, bounds check and division pipeline.
//
//  channel | ports                              | handshake
//  input   | req_point_x/y/z                    | start & !busy
//  result  | rsp_echo_*, rsp_pixel_*, rsp_in_image | done strobe, one cycle
//  config  | csr_we, csr_index, csr_wdata       | csr_we
//
// One item per cycle; the latency is set by the three-stage row sum, one range
// stage, one quotient bit per division stage and the output register.
// busy is always low. Synchronous reset clears coefficients and valid bits.
// Results cannot be held off, so the pipeline never stalls.
`timescale 1ns / 1ps
module lidar_point_to_pixel_projection_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic        csr_we,
   input  logic [lppp_pkg::IDXW-1:0] csr_index,
   input  logic [63:0] csr_wdata,
   output logic        done,
   output logic signed [31:0] rsp_echo_x,
   output logic signed [31:0] rsp_echo_y,
   output logic signed [31:0] rsp_echo_z,
   output logic [10:0] rsp_pixel_column,
   output logic [10:0] rsp_pixel_row,
   output logic        rsp_in_image
);
   import lppp_pkg::*;
   localparam int LAT = 3 + 1 + DIVST;

   logic [63:0] regs_ff [NREG];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NREG; i++) regs_ff[i] <= '0;
      end else if (csr_we && csr_index < IDXW'(NREG)) begin
         regs_ff[csr_index] <= csr_wdata;
      end
   end

   row_coef_type cc, rc, dc;
   assign cc = {regs_ff[REG_COL_A][31:0], regs_ff[REG_COL_A][63:32],
                regs_ff[REG_COL_B][31:0], regs_ff[REG_COL_B][63:32]};
   assign rc = {regs_ff[REG_ROW_A][31:0], regs_ff[REG_ROW_A][63:32],
                regs_ff[REG_ROW_B][31:0], regs_ff[REG_ROW_B][63:32]};
   assign dc = {regs_ff[REG_DEPTH_A][31:0], regs_ff[REG_DEPTH_A][63:32],
                regs_ff[REG_DEPTH_B][31:0], regs_ff[REG_DEPTH_B][63:32]};

   point_type pt;
   assign pt = {req_point_x, req_point_y, req_point_z};
   assign busy = 1'b0;

   logic signed [ACCW-1:0] cn, rn, dp;
   lppp_row_eval u_col (.clock(clock), .coef(cc), .pt(pt), .sum(cn));
   lppp_row_eval u_row (.clock(clock), .coef(rc), .pt(pt), .sum(rn));
   lppp_row_eval u_dep (.clock(clock), .coef(dc), .pt(pt), .sum(dp));

   // valid and echo shift line across the whole pipeline
   logic      vld_ff [LAT];
   point_type echo_ff [LAT];
   always_ff @(posedge clock) begin
      vld_ff[0]  <= reset ? 1'b0 : (start && !busy);
      echo_ff[0] <= pt;
      for (int i = 1; i < LAT; i++) begin
         vld_ff[i]  <= reset ? 1'b0 : vld_ff[i-1];
         echo_ff[i] <= echo_ff[i-1];
      end
   end

   // range stage: compare against -d and limit*d
   logic signed [ACCW+QW-1:0] limc, limr, nd;
   logic okc, okr, posd;
   assign nd   = -(ACCW+QW)'(dp);
   assign limc = (ACCW+QW)'(dp) * (ACCW+QW)'(IMAGE_WIDTH);
   assign limr = (ACCW+QW)'(dp) * (ACCW+QW)'(IMAGE_HEIGHT);
   assign posd = dp > 0;
   assign okc  = (ACCW+QW)'(cn) > nd && (ACCW+QW)'(cn) < limc;
   assign okr  = (ACCW+QW)'(rn) > nd && (ACCW+QW)'(rn) < limr;

   logic [ACCW-1:0] d_s [DIVST+1];
   logic [ACCW-1:0] rc_s [DIVST+1];
   logic [ACCW-1:0] rr_s [DIVST+1];
   logic [QW-1:0]   qc_s [DIVST+1];
   logic [QW-1:0]   qr_s [DIVST+1];
   logic ok_ff [DIVST+1];
   always_ff @(posedge clock) begin
      d_s[0]  <= dp;
      rc_s[0] <= cn[ACCW-1] ? '0 : cn;     // (-1,0) truncates to zero
      rr_s[0] <= rn[ACCW-1] ? '0 : rn;
      qc_s[0] <= '0;
      qr_s[0] <= '0;
      ok_ff[0] <= posd && okc && okr;
      for (int i = 1; i <= DIVST; i++) ok_ff[i] <= ok_ff[i-1];
   end

   genvar g;
   generate
      for (g = 0; g < DIVST; g++) begin : g_div
         lppp_div_stage u_st (
            .clock(clock), .bit_sel(4'(QW-1-g)), .d(d_s[g]),
            .rem_c(rc_s[g]), .rem_r(rr_s[g]), .q_c(qc_s[g]), .q_r(qr_s[g]),
            .d_o(d_s[g+1]), .rem_c_o(rc_s[g+1]), .rem_r_o(rr_s[g+1]),
            .q_c_o(qc_s[g+1]), .q_r_o(qr_s[g+1]));
      end
   endgenerate

   logic done_ff, inimg_ff;
   logic [PIXW-1:0] col_ff, row_ff;
   point_type out_echo_ff;
   always_ff @(posedge clock) begin
      done_ff     <= reset ? 1'b0 : vld_ff[LAT-1];
      inimg_ff    <= ok_ff[DIVST];
      col_ff      <= ok_ff[DIVST] ? qc_s[DIVST][PIXW-1:0] : '0;
      row_ff      <= ok_ff[DIVST] ? qr_s[DIVST][PIXW-1:0] : '0;
      out_echo_ff <= echo_ff[LAT-1];
   end

   assign done             = done_ff;
   assign rsp_in_image     = inimg_ff;
   assign rsp_pixel_column = col_ff;
   assign rsp_pixel_row    = row_ff;
   assign rsp_echo_x       = out_echo_ff.x;
   assign rsp_echo_y       = out_echo_ff.y;
   assign rsp_echo_z       = out_echo_ff.z;

   a_not_in_zero: assert property (@(posedge clock) disable iff (reset)
      (done && !rsp_in_image) |-> (rsp_pixel_column == '0 && rsp_pixel_row == '0))
      else $error("pixel not cleared outside image");
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      (done && rsp_in_image) |->
         (rsp_pixel_column < PIXW'(IMAGE_WIDTH) && rsp_pixel_row < PIXW'(IMAGE_HEIGHT)))
      else $error("pixel out of bounds");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(LAT+1) done)
      else $error("item lost");
endmodule

// ===== tb/tb_lidar_point_to_pixel_projection_top.sv =====
// Self-checking testbench for the lidar point to pixel projection block.
`timescale 1ns / 1ps
module tb_lidar_point_to_pixel_projection_top;
   import lppp_pkg::*;

   localparam logic [IDXW-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [IDXW-1:0] REG_SPARE_7 = 3'd7;
   localparam int    SETTLE_CYCLES = 25;
   localparam int    ONE_M         = 65536;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [10:0]        column;
      logic [10:0]        row;
      logic               in_image;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic        csr_we = 1'b0;
   logic [IDXW-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;
   logic        done;
   logic signed [31:0] rsp_echo_x, rsp_echo_y, rsp_echo_z;
   logic [10:0] rsp_pixel_column, rsp_pixel_row;
   logic        rsp_in_image;

   logic [63:0] coeff_bank [NREG];
   point_type   point_queue [$];
   pixel_type   pixel_due [$];
   int          mismatches = 0;
   int          gap_left = 0;
   bit          quiet_run = 1'b0;

   lidar_point_to_pixel_projection_top u_dut (.*);

   always #10 clock = ~clock;

   function automatic logic signed [127:0] row_sum(input logic [63:0] a, input logic [63:0] b,
                                                   input point_type p);
      logic signed [31:0] cx, cy, cz, ck;
      cx = a[31:0];
      cy = a[63:32];
      cz = b[31:0];
      ck = b[63:32];
      return 128'(cx) * 128'(p.x) + 128'(cy) * 128'(p.y) + 128'(cz) * 128'(p.z)
             + (128'(ck) <<< 16);
   endfunction

   // Truncated quotient, valid only when it falls within [0, lim).
   function automatic bit pixel_fits(input logic signed [127:0] n, input logic signed [127:0] d,
                                     input int lim, output logic [10:0] q);
      q = '0;
      if (n <= -d) return 1'b0;
      if (n >= d * 128'(lim)) return 1'b0;
      if (n >= 0) q = 11'(n / d);
      return 1'b1;
   endfunction

   function automatic pixel_type project_point(input point_type p);
      pixel_type r;
      logic signed [127:0] cn, rn, dp;
      logic [10:0] c, w;
      bit ok;
      cn = row_sum(coeff_bank[REG_COL_A], coeff_bank[REG_COL_B], p);
      rn = row_sum(coeff_bank[REG_ROW_A], coeff_bank[REG_ROW_B], p);
      dp = row_sum(coeff_bank[REG_DEPTH_A], coeff_bank[REG_DEPTH_B], p);
      ok = 1'b0;
      c = '0;
      w = '0;
      if (dp > 0) begin
         ok = pixel_fits(cn, dp, IMAGE_WIDTH, c);
         if (ok) ok = pixel_fits(rn, dp, IMAGE_HEIGHT, w);
      end
      r.x = p.x;
      r.y = p.y;
      r.z = p.z;
      r.column = ok ? c : 11'd0;
      r.row = ok ? w : 11'd0;
      r.in_image = ok;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_run || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Feed items and record the pixel each accepted item should produce.
   always @(posedge clock) begin : drive_points
      point_type pt;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            pt.x = req_point_x;
            pt.y = req_point_y;
            pt.z = req_point_z;
            pixel_due.insert(pixel_due.size(), project_point(pt));
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               start <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (point_queue.size() > 0) begin
               pt = point_queue.pop_front();
               req_point_x <= pt.x;
               req_point_y <= pt.y;
               req_point_z <= pt.z;
               start <= 1'b1;
               gap_left <= pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_pixels
      pixel_type e;
      if (!reset && done) begin
         if (pixel_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result x=%h y=%h z=%h",
                                           rsp_echo_x, rsp_echo_y, rsp_echo_z);
         end else begin
            e = pixel_due.pop_front();
            if (rsp_echo_x !== e.x || rsp_echo_y !== e.y || rsp_echo_z !== e.z ||
                rsp_pixel_column !== e.column || rsp_pixel_row !== e.row ||
                rsp_in_image !== e.in_image) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %h %h %h col %0d row %0d in %b, got %h %h %h col %0d row %0d in %b",
                           e.x, e.y, e.z, e.column, e.row, e.in_image,
                           rsp_echo_x, rsp_echo_y, rsp_echo_z,
                           rsp_pixel_column, rsp_pixel_row, rsp_in_image);
            end
         end
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (point_queue.size() != 0 || start || pixel_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [IDXW-1:0] idx, input logic [63:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      if (idx < NREG) coeff_bank[idx] = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      point_queue.insert(point_queue.size(), p);
   endtask

   // Pinhole camera looking along z: column = f*x/z + cx, row = f*y/z + cy.
   task automatic load_camera(input int f, input int cx, input int cy);
      write_csr(REG_COL_A, {32'd0, 32'(f * ONE_M)});
      write_csr(REG_COL_B, {32'd0, 32'(cx * ONE_M)});
      write_csr(REG_ROW_A, {32'(f * ONE_M), 32'd0});
      write_csr(REG_ROW_B, {32'd0, 32'(cy * ONE_M)});
      write_csr(REG_DEPTH_A, 64'd0);
      write_csr(REG_DEPTH_B, {32'd0, 32'(ONE_M)});
   endtask

   task automatic add_random_points(input int count, input bit scene);
      int zq, roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         zq = $urandom_range(ONE_M / 2, 60 * ONE_M);
         if (!scene || roll < 10)
            add_point($urandom, $urandom, $urandom);
         else if (roll < 15)
            add_point($urandom_range(0, 2 * zq) - zq, $urandom_range(0, 2 * zq) - zq, -zq);
         else
            add_point($urandom_range(0, 2 * zq) - zq, $urandom_range(0, zq) - zq / 2, zq);
      end
   endtask

   initial begin
      for (int i = 0; i < NREG; i++) coeff_bank[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // all coefficients zero: depth zero everywhere
      add_point(32'sd0, 32'sd0, 32'sd0);
      add_point(32'h7fffffff, 32'h80000000, 32'h12345678);
      wait_idle();

      // constant depth of one metre: pixel equals the point in metres
      write_csr(REG_COL_A, {32'd0, 32'(ONE_M)});
      write_csr(REG_ROW_A, {32'(ONE_M), 32'd0});
      write_csr(REG_DEPTH_B, {32'(ONE_M), 32'd0});
      add_point(32'sd0, 32'sd0, 32'sd0);
      add_point(1919 * ONE_M + ONE_M / 2, 1079 * ONE_M + ONE_M / 2, 32'sd5);
      add_point(1920 * ONE_M, 32'sd0, 32'sd0);
      add_point(32'sd0, 1080 * ONE_M, 32'sd0);
      add_point(-ONE_M / 2, -ONE_M / 2, 32'sd0);
      add_point(-ONE_M, 32'sd0, 32'sd0);
      add_point(32'sd0, -ONE_M, 32'sd0);
      add_point(32'h80000000, 32'h7fffffff, -32'sd1);
      add_point(32'h7fffffff, 32'h80000000, 32'h80000000);
      add_point(ONE_M, ONE_M, 32'h7fffffff);
      wait_idle();

      // depth follows z
      write_csr(REG_DEPTH_B, 64'd0);
      write_csr(REG_DEPTH_A, 64'd0);
      write_csr(REG_DEPTH_B, {32'd0, 32'(ONE_M)});
      add_point(100 * ONE_M, 50 * ONE_M, ONE_M);
      add_point(ONE_M, ONE_M, 32'sd0);
      add_point(ONE_M, ONE_M, -ONE_M);
      add_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      add_point(32'sd1, 32'sd1, 32'sd1);
      add_point(-32'sd1, -32'sd1, 32'sd2);
      add_point(32'sd0, 32'sd0, 32'h80000000);
      add_point(-32'sd1, 32'sd0, 32'sd1);
      wait_idle();

      load_camera(1000, 960, 540);
      add_random_points(450, 1'b1);
      wait_idle();

      // pause with nothing in flight, then run without idling
      quiet_run = 1'b1;
      add_random_points(150, 1'b1);
      wait_idle();
      quiet_run = 1'b0;

      for (int i = 0; i < NREG; i++) write_csr(IDXW'(i), {$urandom, $urandom});
      add_random_points(250, 1'b0);
      wait_idle();

      for (int i = 0; i < NREG; i++) write_csr(IDXW'(i), {32'h80000000, 32'h80000000});
      add_random_points(120, 1'b0);
      wait_idle();

      for (int i = 0; i < NREG; i++) write_csr(IDXW'(i), {32'h7fffffff, 32'h7fffffff});
      add_random_points(120, 1'b0);
      wait_idle();

      for (int i = 0; i < NREG; i++) write_csr(IDXW'(i), 64'hffffffffffffffff);
      add_random_points(80, 1'b0);
      wait_idle();

      // writes to spare indexes must leave the camera untouched
      load_camera(-800, 1200, 300);
      write_csr(REG_SPARE_6, {$urandom, $urandom});
      write_csr(REG_SPARE_7, {$urandom, $urandom});
      add_random_points(550, 1'b1);
      wait_idle();

      if (mismatches == 0 && pixel_due.size() == 0) begin
         $display("tb_lidar_point_to_pixel_projection_top: clean");
      end else begin
         $display("tb_lidar_point_to_pixel_projection_top: errors");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("tb_lidar_point_to_pixel_projection_top: errors");
      $finish;
   end
endmodule
